// ===== hw/rtl/bqbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqbd_pkg
// Shared types and constants for the breakpoint quantizer with bound distances.
// ----------------------------------------------------------------------------
package bqbd_pkg;

  localparam int MAX_DIMS        = 16;
  localparam int DIM_W           = $clog2(MAX_DIMS);
  localparam int MAX_SYMBOL_BITS = 8;
  localparam int SYM_W           = MAX_SYMBOL_BITS;
  localparam int VALUE_BITS      = 24;
  localparam int ABITS_W         = 4;
  localparam int SLOTS_PER_DIM   = (1 << MAX_SYMBOL_BITS) - 1;
  localparam int ADDR_W          = DIM_W + SYM_W;
  localparam int RAM_DEPTH       = 1 << ADDR_W;
  localparam int GAP_W           = VALUE_BITS;
  localparam int SQ_W            = 2 * GAP_W;
  localparam int DIST_W          = 63;
  localparam int IDX_W           = SYM_W + 2;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [DIST_W-1:0]     DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [ABITS_W-1:0]    ALPHA_RESET = ABITS_W'(MAX_SYMBOL_BITS);

  typedef enum logic [2:0] {
    OP_LOAD_BP  = 3'd0,
    OP_LOAD_LB  = 3'd1,
    OP_LOAD_UB  = 3'd2,
    OP_ENCODE   = 3'd3,
    OP_DISTANCE = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SRCH, S_SCMP, S_RD_LO, S_RD_HI,
    S_CAP_HI, S_MUL_L, S_MUL_U, S_ACC, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic [DIM_W-1:0]             dim;
    logic [SYM_W-1:0]             slot;
    logic signed [VALUE_BITS-1:0] value;
    logic [SYM_W-1:0]             symbol;
    logic [3:0]                   symbol_bits;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [SYM_W-1:0]  code;
    logic [DIST_W-1:0] dist_lo;
    logic [DIST_W-1:0] dist_hi;
  } res_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic wr_bp;
    logic wr_bound;
    logic srch_init;
    logic srch_upd;
    logic rd_lo;
    logic rd_hi;
    logic cap_lo;
    logic cap_hi;
    logic mul_l;
    logic mul_u;
    logic acc;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       go;
    logic       last;
    logic       clr_last;
    logic       out_free;
  } status_t;

endpackage

// ===== hw/rtl/bqbd_if.sv =====
// ----------------------------------------------------------------------------
// bqbd interfaces
// Valid/ready channels for items, results and configuration words.
// ----------------------------------------------------------------------------
interface bqbd_in_if
  import bqbd_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic [DIM_W-1:0]             dim;
  logic [SYM_W-1:0]             slot;
  logic signed [VALUE_BITS-1:0] value;
  logic [SYM_W-1:0]             symbol;
  logic [3:0]                   symbol_bits;
  logic                         last;
  modport source (output valid, opcode, dim, slot, value, symbol, symbol_bits, last,
                  input ready);
  modport sink (input valid, opcode, dim, slot, value, symbol, symbol_bits, last,
                output ready);
endinterface

interface bqbd_out_if
  import bqbd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SYM_W-1:0]  code;
  logic [DIST_W-1:0] dist_lo;
  logic [DIST_W-1:0] dist_hi;
  modport source (output valid, kind, code, dist_lo, dist_hi, input ready);
  modport sink (input valid, kind, code, dist_lo, dist_hi, output ready);
endinterface

interface bqbd_cfg_if
  import bqbd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ABITS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/breakpoint_quantizer_bound_distance.sv =====
// ----------------------------------------------------------------------------
// breakpoint_quantizer_bound_distance
// Breakpoint encoder and region bound distance accumulator.
// ----------------------------------------------------------------------------
// A load is captured, then written. An encode runs a binary search through the
// registered breakpoint memory port; a distance element reads both region edges,
// squares both gaps and accumulates. An encode, and a last distance element, load
// their word once the output register is free, where it waits until taken. One
// item is in work at a time. After reset all 4096 breakpoint memory entries are
// cleared, while no item is taken; configuration words are taken at any time.
module breakpoint_quantizer_bound_distance
  import bqbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bqbd_in_if.sink     in_ch,
  bqbd_out_if.source  out_ch,
  bqbd_cfg_if.sink    cfg_ch
);

  logic [ABITS_W-1:0] alpha_r;
  cmd_t               cmd;
  status_t            st;
  item_t              item;
  res_t               res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_ch.valid) begin
      alpha_r <= cfg_ch.data;
    end
  end

  assign item.opcode      = in_ch.opcode;
  assign item.dim         = in_ch.dim;
  assign item.slot        = in_ch.slot;
  assign item.value       = in_ch.value;
  assign item.symbol      = in_ch.symbol;
  assign item.symbol_bits = in_ch.symbol_bits;
  assign item.last        = in_ch.last;

  bqbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  bqbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .item      (item),
    .alpha     (alpha_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.kind    = res.kind;
  assign out_ch.code    = res.code;
  assign out_ch.dist_lo = res.dist_lo;
  assign out_ch.dist_hi = res.dist_hi;

endmodule

// ===== hw/rtl/bqbd_ram.sv =====
// ----------------------------------------------------------------------------
// bqbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bqbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bqbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqbd_ctrl
// Sequencer for table clearing, loads, binary search and distance steps.
// ----------------------------------------------------------------------------
module bqbd_ctrl
  import bqbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        case (st.opcode)
          OP_ENCODE:   state_nxt = S_SRCH;
          OP_DISTANCE: state_nxt = S_RD_LO;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_SRCH:   state_nxt = st.go ? S_SCMP : S_OUT;
      S_SCMP:   state_nxt = S_SRCH;
      S_RD_LO:  state_nxt = S_RD_HI;
      S_RD_HI:  state_nxt = S_CAP_HI;
      S_CAP_HI: state_nxt = S_MUL_L;
      S_MUL_L:  state_nxt = S_MUL_U;
      S_MUL_U:  state_nxt = S_ACC;
      S_ACC:    state_nxt = st.last ? S_OUT : S_IDLE;
      S_OUT:    if (st.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.wr_bp     = (st.opcode == OP_LOAD_BP);
        cmd.wr_bound  = st.opcode inside {OP_LOAD_LB, OP_LOAD_UB};
        cmd.srch_init = (st.opcode == OP_ENCODE);
      end
      S_SCMP:   cmd.srch_upd = 1'b1;
      S_RD_LO:  cmd.rd_lo = 1'b1;
      S_RD_HI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = 1'b1;
      end
      S_CAP_HI: cmd.cap_hi = 1'b1;
      S_MUL_L:  cmd.mul_l = 1'b1;
      S_MUL_U:  cmd.mul_u = 1'b1;
      S_ACC:    cmd.acc = 1'b1;
      S_OUT:    cmd.out_ld = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bqbd_dp.sv =====
// ----------------------------------------------------------------------------
// bqbd_dp
// Datapath: breakpoint memory, bound registers, search, squaring and sums.
// ----------------------------------------------------------------------------
module bqbd_dp
  import bqbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  item_t              item,
  input  logic [ABITS_W-1:0] alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output res_t               res
);

  item_t                        it_r;
  logic [ADDR_W-1:0]            clr_cnt_r;
  logic signed [VALUE_BITS-1:0] lb_r [MAX_DIMS];
  logic signed [VALUE_BITS-1:0] ub_r [MAX_DIMS];
  logic signed [IDX_W-1:0]      lo_r, hi_r;
  logic signed [VALUE_BITS-1:0] elo_r, ehi_r;
  logic [SQ_W-1:0]              sql_r, squ_r;
  logic [DIST_W-1:0]            lacc_r, uacc_r;
  logic                         out_valid_r;
  res_t                         res_r;

  logic [ABITS_W-1:0]           a, cc, shift;
  logic [SYM_W-1:0]             top, rlo, rhi;
  logic signed [IDX_W-1:0]      idx_sum;
  logic [SYM_W-1:0]             mid;
  logic                         ram_we;
  logic [ADDR_W-1:0]            waddr, raddr;
  logic [VALUE_BITS-1:0]        wdata, rdata;
  logic signed [VALUE_BITS:0]   dl, du;
  logic [GAP_W-1:0]             gl, gu;
  logic                         below, above;
  logic [DIST_W:0]              lsum, usum;

  always_comb begin
    a = alpha;
    if (a == '0) a = ABITS_W'(1);
    if (a > ABITS_W'(MAX_SYMBOL_BITS)) a = ABITS_W'(MAX_SYMBOL_BITS);
    top   = SYM_W'((9'(1) << a) - 9'(1));
    cc    = (it_r.symbol_bits > a) ? a : it_r.symbol_bits;
    shift = a - cc;
    rlo   = SYM_W'({8'd0, it_r.symbol} << shift) & top;
    rhi   = rlo | SYM_W'((9'(1) << shift) - 9'(1));
  end

  assign idx_sum = lo_r + hi_r;
  assign mid     = idx_sum[SYM_W:1];

  always_comb begin
    ram_we = 1'b0;
    waddr  = clr_cnt_r;
    wdata  = VALUE_MAX;
    if (cmd.clr) begin
      ram_we = 1'b1;
    end else if (cmd.wr_bp && (it_r.slot != SYM_W'(SLOTS_PER_DIM))) begin
      ram_we = 1'b1;
      waddr  = {it_r.dim, it_r.slot};
      wdata  = it_r.value;
    end
    if (cmd.rd_lo) begin
      raddr = {it_r.dim, rlo - SYM_W'(1)};
    end else if (cmd.rd_hi) begin
      raddr = {it_r.dim, rhi};
    end else begin
      raddr = {it_r.dim, mid};
    end
  end

  bqbd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_bp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    below = elo_r > it_r.value;
    above = ehi_r < it_r.value;
    if (below) begin
      dl = {elo_r[VALUE_BITS-1], elo_r} - {it_r.value[VALUE_BITS-1], it_r.value};
      du = {ehi_r[VALUE_BITS-1], ehi_r} - {it_r.value[VALUE_BITS-1], it_r.value};
    end else begin
      dl = {it_r.value[VALUE_BITS-1], it_r.value} - {ehi_r[VALUE_BITS-1], ehi_r};
      du = {it_r.value[VALUE_BITS-1], it_r.value} - {elo_r[VALUE_BITS-1], elo_r};
    end
    gl = dl[VALUE_BITS] ? GAP_W'(-dl) : GAP_W'(dl);
    gu = du[VALUE_BITS] ? GAP_W'(-du) : GAP_W'(du);
    lsum = {1'b0, lacc_r} + (DIST_W + 1)'(sql_r);
    usum = {1'b0, uacc_r} + (DIST_W + 1)'(squ_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      lacc_r      <= '0;
      uacc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (cmd.acc && (below || above)) begin
        lacc_r <= (lsum > {1'b0, DIST_MAX}) ? DIST_MAX : lsum[DIST_W-1:0];
        uacc_r <= (usum > {1'b0, DIST_MAX}) ? DIST_MAX : usum[DIST_W-1:0];
      end
      if (cmd.out_ld && (it_r.opcode == OP_DISTANCE)) begin
        lacc_r <= '0;
        uacc_r <= '0;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) it_r <= item;
    if (cmd.wr_bound) begin
      if (it_r.opcode == OP_LOAD_LB) lb_r[it_r.dim] <= it_r.value;
      else ub_r[it_r.dim] <= it_r.value;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= $signed({2'b00, top}) - IDX_W'(1);
    end else if (cmd.srch_upd) begin
      if (it_r.value >= $signed(rdata)) lo_r <= $signed({2'b00, mid}) + IDX_W'(1);
      else hi_r <= $signed({2'b00, mid}) - IDX_W'(1);
    end
    if (cmd.cap_lo) elo_r <= (rlo == '0) ? lb_r[it_r.dim] : $signed(rdata);
    if (cmd.cap_hi) ehi_r <= (rhi == top) ? ub_r[it_r.dim] : $signed(rdata);
    if (cmd.mul_l) sql_r <= gl * gl;
    if (cmd.mul_u) squ_r <= gu * gu;
    if (cmd.out_ld) begin
      if (it_r.opcode == OP_DISTANCE) begin
        res_r.kind    <= 1'b1;
        res_r.code    <= '0;
        res_r.dist_lo <= lacc_r;
        res_r.dist_hi <= uacc_r;
      end else begin
        res_r.kind    <= 1'b0;
        res_r.code    <= lo_r[SYM_W-1:0];
        res_r.dist_lo <= '0;
        res_r.dist_hi <= '0;
      end
    end
  end

  assign st.opcode   = it_r.opcode;
  assign st.go       = lo_r <= hi_r;
  assign st.last     = it_r.last;
  assign st.clr_last = clr_cnt_r == ADDR_W'(RAM_DEPTH - 1);
  assign st.out_free = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign res         = res_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the breakpoint quantizer with bound distances: items
// are driven with random gaps, results are checked against a local predictor.
// ----------------------------------------------------------------------------
module tb;
  import bqbd_pkg::*;

  logic clk;
  logic rst_n;

  bqbd_in_if  in_if ();
  bqbd_out_if out_if ();
  bqbd_cfg_if cfg_if ();

  breakpoint_quantizer_bound_distance DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predictor state.
  int          bp_tab [MAX_DIMS][SLOTS_PER_DIM];
  int          lb_tab [MAX_DIMS];
  int          ub_tab [MAX_DIMS];
  logic [63:0] lower_sum;
  logic [63:0] upper_sum;
  logic [3:0]  alpha_bits;

  res_t        pending_words [$];
  int          fails;
  int          idle_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add);
    logic [63:0] dmax;
    dmax = 64'h7FFF_FFFF_FFFF_FFFF;
    if (acc > dmax) acc = dmax;
    if (add > dmax - acc) return dmax;
    return acc + add;
  endfunction

  function automatic logic [63:0] gap_sq(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return 64'(d) * 64'(d);
  endfunction

  function automatic void predict_word(item_t it);
    int   d, a, top, lo, hi, mid, cc, sh, rlo, rhi, v, elo, ehi;
    res_t r;
    d = it.dim;
    v = int'($signed(it.value));
    a = alpha_bits;
    if (a < 1) a = 1;
    if (a > MAX_SYMBOL_BITS) a = MAX_SYMBOL_BITS;
    top = (1 << a) - 1;
    r = '0;
    case (it.opcode)
      OP_LOAD_BP: begin
        if (it.slot < SLOTS_PER_DIM) bp_tab[d][it.slot] = v;
      end
      OP_LOAD_LB: lb_tab[d] = v;
      OP_LOAD_UB: ub_tab[d] = v;
      OP_ENCODE: begin
        lo = 0;
        hi = top - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (v >= bp_tab[d][mid]) lo = mid + 1;
          else hi = mid - 1;
        end
        r.code = lo[7:0];
        pending_words.push_back(r);
      end
      OP_DISTANCE: begin
        cc = (it.symbol_bits > a) ? a : it.symbol_bits;
        sh = a - cc;
        rlo = (it.symbol << sh) & top;
        rhi = rlo | ((1 << sh) - 1);
        elo = (rlo == 0) ? lb_tab[d] : bp_tab[d][rlo-1];
        ehi = (rhi == top) ? ub_tab[d] : bp_tab[d][rhi];
        if (elo > v) begin
          lower_sum = sat_add(lower_sum, gap_sq(elo, v));
          upper_sum = sat_add(upper_sum, gap_sq(ehi, v));
        end else if (ehi < v) begin
          lower_sum = sat_add(lower_sum, gap_sq(v, ehi));
          upper_sum = sat_add(upper_sum, gap_sq(v, elo));
        end
        if (it.last) begin
          r.kind = 1'b1;
          r.dist_lo = lower_sum[62:0];
          r.dist_hi = upper_sum[62:0];
          pending_words.push_back(r);
          lower_sum = '0;
          upper_sum = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    res_t want;
    out_if.ready <= ($urandom_range(99) >= idle_pct);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_if.kind, 0);
      end else begin
        want = pending_words.pop_front();
        if (out_if.kind !== want.kind) report_mismatch("kind", out_if.kind, want.kind);
        if (out_if.code !== want.code) report_mismatch("code", out_if.code, want.code);
        if (out_if.dist_lo !== want.dist_lo)
          report_mismatch("lower", out_if.dist_lo, want.dist_lo);
        if (out_if.dist_hi !== want.dist_hi)
          report_mismatch("upper", out_if.dist_hi, want.dist_hi);
      end
    end
  end

  function automatic item_t mk(logic [2:0] op, logic [3:0] d, logic [7:0] sl,
                               logic [23:0] v, logic [7:0] sy, logic [3:0] sb,
                               logic la);
    item_t it;
    it.opcode = op;
    it.dim = d;
    it.slot = sl;
    it.value = v;
    it.symbol = sy;
    it.symbol_bits = sb;
    it.last = la;
    return it;
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= it.opcode;
    in_if.dim         <= it.dim;
    in_if.slot        <= it.slot;
    in_if.value       <= it.value;
    in_if.symbol      <= it.symbol;
    in_if.symbol_bits <= it.symbol_bits;
    in_if.last        <= it.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(it);
  endtask

  task automatic drain_words();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_alphabet(logic [3:0] bits);
    drain_words();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= bits;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    alpha_bits = bits;
  endtask

  function automatic logic [23:0] rand_value();
    if ($urandom_range(1)) return 24'($urandom);
    return 24'($signed($urandom_range(8000)) - 4000) <<< $urandom_range(10);
  endfunction

  task automatic load_sorted(int d, int count);
    int v;
    v = -8388608 + $urandom_range(200000);
    for (int s = 0; s < count; s++) begin
      send_item(mk(OP_LOAD_BP, 4'(d), 8'(s), 24'(v), 8'($urandom), 4'($urandom), 1'($urandom)));
      v += $urandom_range(60000);
    end
  endtask

  task automatic load_all_bounds();
    for (int d = 0; d < MAX_DIMS; d++) begin
      send_item(mk(OP_LOAD_LB, 4'(d), 8'($urandom), 24'(-$urandom_range(8388608)), 0, 0, 0));
      send_item(mk(OP_LOAD_UB, 4'(d), 8'($urandom), 24'($urandom_range(8388607)), 0, 0, 0));
    end
  endtask

  task automatic test_directed();
    load_all_bounds();
    send_item(mk(OP_ENCODE, 0, 0, 24'h7FFFFF, 0, 0, 0));
    send_item(mk(OP_ENCODE, 15, 0, 24'h800000, 0, 0, 0));
    send_item(mk(OP_LOAD_BP, 15, 255, 24'h000000, 0, 0, 0));
    send_item(mk(OP_LOAD_BP, 15, 254, 24'h800000, 0, 0, 0));
    send_item(mk(OP_LOAD_BP, 15, 0, 24'h000100, 0, 0, 0));
    send_item(mk(OP_ENCODE, 15, 0, 24'h000100, 0, 0, 0));
    send_item(mk(OP_ENCODE, 15, 0, 24'h0000FF, 0, 0, 0));
    send_item(mk(OP_DISTANCE, 15, 0, 24'h800000, 255, 8, 0));
    send_item(mk(OP_DISTANCE, 3, 0, 24'h7FFFFF, 0, 0, 0));
    send_item(mk(OP_DISTANCE, 15, 0, 24'h7FFFFF, 255, 15, 1));
    send_item(mk(OP_DISTANCE, 7, 0, 24'h000000, 255, 3, 1));
    send_item(mk(OP_DISTANCE, 0, 0, 24'h800000, 0, 15, 1));
    send_item(mk(3'd5, 1, 0, 24'h123456, 0, 0, 1));
    send_item(mk(3'd6, 2, 0, 24'h123456, 0, 0, 1));
    send_item(mk(3'd7, 3, 0, 24'h123456, 0, 0, 1));
  endtask

  task automatic random_mix(int count);
    int len, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(mk(OP_ENCODE, 4'($urandom), 8'($urandom), rand_value(), 8'($urandom),
                     4'($urandom), 1'($urandom)));
      end else if (pick < 80) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          send_item(mk(OP_DISTANCE, 4'($urandom), 8'($urandom), rand_value(), 8'($urandom),
                       4'($urandom), k == len - 1));
      end else if (pick < 90) begin
        send_item(mk(3'($urandom_range(2)), 4'($urandom), 8'($urandom), rand_value(),
                     8'($urandom), 4'($urandom), 1'($urandom)));
      end else begin
        send_item(mk(3'($urandom_range(5, 7)), 4'($urandom), 8'($urandom), rand_value(),
                     8'($urandom), 4'($urandom), 1'($urandom)));
      end
    end
  endtask

  task automatic test_small_alphabet();
    write_alphabet(4'd3);
    for (int d = 0; d < MAX_DIMS; d++) load_sorted(d, 7);
    random_mix(70);
    drain_words();
    random_mix(40);
  endtask

  task automatic test_full_alphabet();
    write_alphabet(4'd8);
    load_sorted(5, 255);
    idle_pct = 0;
    random_mix(120);
    idle_pct = 36;
  endtask

  task automatic test_edge_alphabets();
    write_alphabet(4'd1);
    for (int d = 0; d < MAX_DIMS; d++) load_sorted(d, 1);
    random_mix(50);
    write_alphabet(4'd0);
    random_mix(40);
    write_alphabet(4'd15);
    random_mix(40);
    write_alphabet(4'd5);
    for (int d = 0; d < 4; d++) load_sorted(d, 31);
    random_mix(50);
  endtask

  initial begin
    fails = 0;
    idle_pct = 36;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.dim = '0;
    in_if.slot = '0;
    in_if.value = '0;
    in_if.symbol = '0;
    in_if.symbol_bits = '0;
    in_if.last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      lb_tab[d] = 0;
      ub_tab[d] = 0;
      for (int s = 0; s < SLOTS_PER_DIM; s++) bp_tab[d][s] = 8388607;
    end
    lower_sum = '0;
    upper_sum = '0;
    alpha_bits = 4'd8;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_alphabet();
    test_full_alphabet();
    test_edge_alphabets();
    drain_words();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/bqbd_pkg.sv
hw/rtl/bqbd_if.sv
hw/rtl/bqbd_ram.sv
hw/rtl/bqbd_ctrl.sv
hw/rtl/bqbd_dp.sv
hw/rtl/breakpoint_quantizer_bound_distance.sv
tb/tb.sv
